// ===== rtl/multipath_ghost_rejector_unit_macros.svh =====
// Assertion helpers for the ghost rejector checker.
`ifndef MULTIPATH_GHOST_REJECTOR_UNIT_MACROS_SVH
`define MULTIPATH_GHOST_REJECTOR_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define MGR_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ghost rejector check failed");

// Next-cycle implication, clocked on clk, off during reset.
`define MGR_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ghost rejector check failed");

`endif

// ===== rtl/mgr_pkg.sv =====
// ----------------------------------------------------------------------------
// mgr_pkg
// Shared constants and types of the multipath ghost rejector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mgr_pkg;

	localparam int MAX_DET = 64;
	localparam int CNT_W   = $clog2(MAX_DET + 1);
	localparam int IDX_W   = $clog2(MAX_DET);
	localparam int AZ_W    = 16;
	localparam int RNG_W   = 16;
	localparam int BIN_W   = 16;
	localparam int NH_W    = 7;
	localparam int RANK_W  = 6;
	localparam int RATIO_W = 16;
	localparam int DIV_W   = 17;
	localparam int PROD_W  = RNG_W + RATIO_W;

	localparam logic [1:0] CFG_ENABLE    = 2'd0;
	localparam logic [1:0] CFG_BIN_WIDTH = 2'd1;
	localparam logic [1:0] CFG_NEAR_HITS = 2'd2;
	localparam logic [1:0] CFG_RATIO     = 2'd3;

	// stored detection held by one cell
	typedef struct packed {
		logic             vld;
		logic [BIN_W-1:0] bin;
		logic [RNG_W-1:0] rng;
		logic             flag;
		logic             qual;
		logic [RNG_W-1:0] med;
	} entry_t;

	// copy circulating around the ring
	typedef struct packed {
		logic             vld;
		logic [BIN_W-1:0] bin;
		logic [RNG_W-1:0] rng;
		logic             med;
	} trav_t;

	// broadcast control to all cells
	typedef struct packed {
		logic              ld1;
		logic              p1;
		logic              ld2;
		logic              p2;
		logic              shift;
		logic [NH_W-1:0]   near_hits;
		logic [RANK_W-1:0] rank;
		logic [BIN_W-1:0]  wr_bin;
		logic [RNG_W-1:0]  wr_rng;
		logic              wr_flag;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/mgr_div.sv =====
// ----------------------------------------------------------------------------
// mgr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mgr_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [mgr_pkg::DIV_W-1:0] num,
	input  wire logic [mgr_pkg::DIV_W-1:0] den,
	output logic                           done,
	output logic [mgr_pkg::DIV_W-1:0]      quo
);
	import mgr_pkg::*;

	localparam int STEP_W = $clog2(DIV_W + 1);

	logic                run_q;
	logic                done_q;
	logic [STEP_W-1:0]   step_q;
	logic [DIV_W-1:0]    num_q;
	logic [DIV_W-1:0]    den_q;
	logic [DIV_W-1:0]    quo_q;
	logic [DIV_W:0]      rem_q;
	logic [DIV_W:0]      trial;
	logic                ge;

	assign trial = {rem_q[DIV_W-1:0], num_q[DIV_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(DIV_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[DIV_W-2:0], 1'b0};
			rem_q <= ge ? (trial - {1'b0, den_q}) : trial;
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

// ===== rtl/mgr_cell.sv =====
// ----------------------------------------------------------------------------
// mgr_cell
// One detection slot: holds an entry, ranks it against the ring traffic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mgr_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mgr_pkg::cell_ctl_t ctl,
	input  wire logic               wr,
	input  wire mgr_pkg::trav_t     trav_i,
	output mgr_pkg::trav_t          trav_o,
	input  wire mgr_pkg::entry_t    ent_i,
	output mgr_pkg::entry_t         ent_o
);
	import mgr_pkg::*;

	entry_t           ent_q;
	trav_t            trav_q;
	logic [CNT_W-1:0] mem_q;
	logic [CNT_W-1:0] less_q;
	logic [CNT_W-1:0] leq_q;
	logic             same;
	logic             is_med;

	assign same   = trav_q.vld && ent_q.vld && (trav_q.bin == ent_q.bin);
	assign is_med = (less_q <= CNT_W'(ctl.rank)) && (CNT_W'(ctl.rank) < leq_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q  <= '0;
			trav_q <= '0;
			mem_q  <= '0;
			less_q <= '0;
			leq_q  <= '0;
		end else begin
			if (wr) begin
				ent_q.vld  <= 1'b1;
				ent_q.bin  <= ctl.wr_bin;
				ent_q.rng  <= ctl.wr_rng;
				ent_q.flag <= ctl.wr_flag;
				ent_q.qual <= 1'b0;
				ent_q.med  <= '0;
			end else if (ctl.shift) begin
				ent_q <= ent_i;
			end else if (ctl.ld2) begin
				ent_q.qual <= mem_q > ctl.near_hits;
			end else if (ctl.p2 && same && trav_q.med) begin
				ent_q.med <= trav_q.rng;
			end

			if (ctl.ld1) begin
				trav_q <= '{vld: ent_q.vld, bin: ent_q.bin, rng: ent_q.rng, med: 1'b0};
			end else if (ctl.ld2) begin
				trav_q <= '{vld: ent_q.vld, bin: ent_q.bin, rng: ent_q.rng, med: is_med};
			end else if (ctl.p1 || ctl.p2) begin
				trav_q <= trav_i;
			end

			if (ctl.ld1) begin
				mem_q  <= '0;
				less_q <= '0;
				leq_q  <= '0;
			end else if (ctl.p1 && same) begin
				mem_q  <= mem_q + CNT_W'(1);
				less_q <= less_q + CNT_W'(trav_q.rng < ent_q.rng);
				leq_q  <= leq_q + CNT_W'(trav_q.rng <= ent_q.rng);
			end
		end
	end

	assign trav_o = trav_q;
	assign ent_o  = ent_q;

endmodule

`default_nettype wire

// ===== rtl/multipath_ghost_rejector_unit.sv =====
// ----------------------------------------------------------------------------
// multipath_ghost_rejector_unit
// Flags multipath ghosts in a frame of radar detections, per azimuth bin.
// ----------------------------------------------------------------------------
// Usage:
//  - Input requests: drive azimuth, distance, prior_occluded, frame_end with
//    start; a request is taken at a clock edge with start high and busy low.
//  - A stored detection keeps busy high while the divider (one quotient bit
//    per cycle) finds its azimuth bin, so no new request is taken before
//    the detection is stored. A detection arriving at a full frame is
//    dropped at once.
//  - The request carrying frame_end closes the frame. The row of 64 cells then
//    runs two ring passes (counting ranks, then handing out each bin's
//    median), after which results leave one per cycle, in input order,
//    through a multiply stage and an output register.
//  - Results: result_valid strobes for one cycle per result; the receiver
//    cannot hold them off. last_result marks the final one of the frame.
//  - Config: cfg_valid/cfg_index/cfg_data, always ready; write only while
//    busy is low.
//  - Reset: clears frame count, overflow flag, cell valid bits and registers
//    to enable 0, bin_width 200, near_hits 3, range_ratio 6144.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multipath_ghost_rejector_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic signed [mgr_pkg::AZ_W-1:0] azimuth,
	input  wire logic [mgr_pkg::RNG_W-1:0]     distance,
	input  wire logic                          prior_occluded,
	input  wire logic                          frame_end,
	output logic                               result_valid,
	output logic [mgr_pkg::IDX_W-1:0]          index,
	output logic                               occluded,
	output logic                               overflow,
	output logic                               last_result,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [15:0]                   cfg_data
);
	import mgr_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DIV   = 3'd1;
	localparam logic [2:0] S_LD1   = 3'd2;
	localparam logic [2:0] S_P1    = 3'd3;
	localparam logic [2:0] S_LD2   = 3'd4;
	localparam logic [2:0] S_P2    = 3'd5;
	localparam logic [2:0] S_EMIT  = 3'd6;
	localparam logic [2:0] S_DRAIN = 3'd7;

	// configuration
	logic                enable_q;
	logic [15:0]         bin_width_q;
	logic [NH_W-1:0]     near_hits_q;
	logic [RATIO_W-1:0]  ratio_q;

	// control
	logic [2:0]          state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    step_q;
	logic                ovf_q;

	// current request
	logic                neg_q;
	logic [RNG_W-1:0]    rng_in_q;
	logic                flag_in_q;
	logic                fe_q;

	logic                accept;
	logic                room;
	logic [15:0]         w_eff;
	logic [15:0]         mag;
	logic                div_done;
	logic [DIV_W-1:0]    quo;
	logic [DIV_W-1:0]    quo_neg;
	logic                wr_en;
	cell_ctl_t           ctl;

	trav_t               trav [MAX_DET];
	entry_t              ent  [MAX_DET+1];

	// emit pipeline
	logic                vld_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic                last_s1;
	logic                flag_s1;
	logic                qual_s1;
	logic                ovf_s1;
	logic [RNG_W-1:0]    rng_s1;
	logic [PROD_W-1:0]   prod_s1;
	logic                vld_s2;
	logic [IDX_W-1:0]    idx_s2;
	logic                occ_s2;
	logic                ovf_s2;
	logic                last_s2;
	logic                ghost;

	assign busy      = state_q != S_IDLE;
	assign accept    = start && !busy;
	assign room      = cnt_q < CNT_W'(MAX_DET);
	assign cfg_ready = 1'b1;
	// zero width behaves as width one
	assign w_eff     = (bin_width_q == 16'd0) ? 16'd1 : bin_width_q;
	assign mag       = azimuth[AZ_W-1] ? (~azimuth + 16'd1) : azimuth;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			bin_width_q <= 16'd200;
			near_hits_q <= NH_W'(3);
			ratio_q     <= RATIO_W'(6144);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ENABLE:    enable_q    <= cfg_data[0];
				CFG_BIN_WIDTH: bin_width_q <= cfg_data;
				CFG_NEAR_HITS: near_hits_q <= cfg_data[NH_W-1:0];
				CFG_RATIO:     ratio_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// bin = round(|az| / w) = (2|az| + w) / (2w), sign restored after
	mgr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && room),
		.num    ({mag, 1'b0} + {1'b0, w_eff}),
		.den    ({w_eff, 1'b0}),
		.done   (div_done),
		.quo    (quo)
	);

	assign quo_neg = ~quo + DIV_W'(1);
	assign wr_en   = (state_q == S_DIV) && div_done;

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q     <= azimuth[AZ_W-1];
			rng_in_q  <= distance;
			flag_in_q <= prior_occluded;
			fe_q      <= frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			step_q  <= '0;
			ovf_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (room) begin
							state_q <= S_DIV;
						end else begin
							ovf_q   <= 1'b1;
							state_q <= frame_end ? S_LD1 : S_IDLE;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						cnt_q   <= cnt_q + CNT_W'(1);
						state_q <= fe_q ? S_LD1 : S_IDLE;
					end
				end
				S_LD1: begin
					step_q  <= '0;
					state_q <= S_P1;
				end
				S_P1: begin
					step_q <= step_q + CNT_W'(1);
					if (step_q == CNT_W'(MAX_DET - 1)) begin
						state_q <= S_LD2;
					end
				end
				S_LD2: begin
					step_q  <= '0;
					state_q <= S_P2;
				end
				S_P2: begin
					step_q <= step_q + CNT_W'(1);
					if (step_q == CNT_W'(MAX_DET - 1)) begin
						step_q  <= '0;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					step_q <= step_q + CNT_W'(1);
					if (CNT_W'(step_q + CNT_W'(1)) == cnt_q) begin
						step_q  <= '0;
						cnt_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					// wait while the last result passes the multiply stage and the output register
					step_q <= step_q + CNT_W'(1);
					if (step_q == CNT_W'(1)) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		ctl           = '0;
		ctl.ld1       = state_q == S_LD1;
		ctl.p1        = state_q == S_P1;
		ctl.ld2       = state_q == S_LD2;
		ctl.p2        = state_q == S_P2;
		ctl.shift     = state_q == S_EMIT;
		ctl.near_hits = near_hits_q;
		ctl.rank      = near_hits_q[NH_W-1:1];
		ctl.wr_bin    = neg_q ? quo_neg[BIN_W-1:0] : quo[BIN_W-1:0];
		ctl.wr_rng    = rng_in_q;
		ctl.wr_flag   = flag_in_q;
	end

	// Row of cells: ring for rank passes, downward shift for emitting.
	assign ent[MAX_DET] = '0;

	for (genvar k = 0; k < MAX_DET; k++) begin : g_cell
		mgr_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.wr     (wr_en && (cnt_q[IDX_W-1:0] == IDX_W'(k))),
			.trav_i (trav[(k + MAX_DET - 1) % MAX_DET]),
			.trav_o (trav[k]),
			.ent_i  (ent[k+1]),
			.ent_o  (ent[k])
		);
	end

	// Stage 1: median times ratio off the head cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= state_q == S_EMIT;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= step_q[IDX_W-1:0];
		last_s1 <= CNT_W'(step_q + CNT_W'(1)) == cnt_q;
		flag_s1 <= ent[0].flag;
		qual_s1 <= ent[0].qual;
		ovf_s1  <= ovf_q;
		rng_s1  <= ent[0].rng;
		prod_s1 <= ent[0].med * ratio_q;
	end

	// Ghost: distance*4096 > median*ratio in a bin with enough members.
	assign ghost = enable_q && qual_s1 &&
		({{(PROD_W-RNG_W-12){1'b0}}, rng_s1, 12'd0} > prod_s1);

	// Stage 2: output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s2  <= idx_s1;
		occ_s2  <= flag_s1 || ghost;
		ovf_s2  <= ovf_s1;
		last_s2 <= last_s1;
	end

	assign result_valid = vld_s2;
	assign index        = idx_s2;
	assign occluded     = occ_s2;
	assign overflow     = ovf_s2;
	assign last_result  = last_s2;

endmodule

`default_nettype wire

// ===== rtl/mgr_chk.sv =====
// ----------------------------------------------------------------------------
// mgr_chk
// Port-level checks on the ghost rejector result stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "multipath_ghost_rejector_unit_macros.svh"

module mgr_chk (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        busy,
	input wire logic                        result_valid,
	input wire logic [mgr_pkg::IDX_W-1:0]   index,
	input wire logic                        last_result
);
	import mgr_pkg::*;

	// results only come out of a frame in progress
	`MGR_ASSERT_IMP(a_res_busy, result_valid, busy)
	// a frame's results come in one unbroken run
	`MGR_ASSERT_NXT(a_res_run, result_valid && !last_result, result_valid)
	// indices count up by one inside the run
	`MGR_ASSERT_NXT(a_res_idx, result_valid && !last_result, index == $past(index) + IDX_W'(1))
	// nothing right after the frame's last result
	`MGR_ASSERT_NXT(a_res_end, result_valid && last_result, !result_valid)

endmodule

bind multipath_ghost_rejector_unit mgr_chk u_mgr_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.busy         (busy),
	.result_valid (result_valid),
	.index        (index),
	.last_result  (last_result)
);

`default_nettype wire
